FILE: hdl/iptlt_pkg.sv
// Package: widths, CORDIC constants, register indices, arctangent table and Q2.30 helpers for the pose transform.
package iptlt_pkg;

	localparam int unsigned CordicSteps = 28;
	localparam int unsigned CordicW     = 34;

	localparam logic signed [CordicW-1:0] PiQ28     = 34'sd843314857;
	localparam logic signed [CordicW-1:0] HalfPiQ28 = 34'sd421657428;
	localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;
	localparam logic signed [CordicW-1:0] OneQ30    = 34'sd1073741824;

	localparam logic [2:0] RegMeridian = 3'd0;
	localparam logic [2:0] RegPrime    = 3'd1;
	localparam logic [2:0] RegOrgEast  = 3'd2;
	localparam logic [2:0] RegOrgNorth = 3'd3;
	localparam logic [2:0] RegOrgUp    = 3'd4;

	function automatic logic signed [CordicW-1:0] atan_q28(input logic [4:0] i);
		logic signed [CordicW-1:0] v;
		case (i)
			5'd0: v = 34'sd210828714;
			5'd1: v = 34'sd124459457;
			5'd2: v = 34'sd65760959;
			5'd3: v = 34'sd33381290;
			5'd4: v = 34'sd16755422;
			5'd5: v = 34'sd8385879;
			5'd6: v = 34'sd4193963;
			5'd7: v = 34'sd2097109;
			5'd8: v = 34'sd1048571;
			5'd9: v = 34'sd524287;
			default: v = (i < 5'd28) ? (34'sd1 <<< (5'd28 - i)) : 34'sd0;
		endcase
		return v;
	endfunction

	// clamp a value to [-2^30, 2^30]
	function automatic logic signed [31:0] clamp_q30(input logic signed [CordicW-1:0] v);
		logic signed [CordicW-1:0] c;
		if (v > OneQ30) c = OneQ30;
		else if (v < -OneQ30) c = -OneQ30;
		else c = v;
		return c[31:0];
	endfunction

	// rounded Q2.30 product
	function automatic logic signed [33:0] mulq(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b + 64'sd536870912;
		return p[63:30];
	endfunction

endpackage

FILE: hdl/imu_pose_to_local_transform.sv
// Top level: pipelined pose sample to rotation matrix and local offset.
//
// One request enters per clock when start is high and busy is low; busy is
// held low, so a request can arrive every cycle. The result leaves with done
// high for one cycle: one stage folds the angles, 28 stages
// run one CORDIC step each for roll, pitch and yaw side by side, one clamps,
// two form the products and one sums and clamps. The offset path (two 32x22
// partial products per axis, round, subtract, saturate) runs alongside in a
// delay line. The receiver cannot stall; done pulses are not held. Writes on
// the configuration port take effect at once and must only happen while no
// request is in flight.
module imu_pose_to_local_transform (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [30:0]  latitude,
	input  logic signed [31:0]  longitude,
	input  logic signed [31:0]  height,
	input  logic signed [30:0]  roll,
	input  logic signed [30:0]  pitch,
	input  logic signed [30:0]  yaw,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [43:0]         cfg_data,
	output logic                done,
	output logic signed [31:0]  r00,
	output logic signed [31:0]  r01,
	output logic signed [31:0]  r02,
	output logic signed [31:0]  r10,
	output logic signed [31:0]  r11,
	output logic signed [31:0]  r12,
	output logic signed [31:0]  r20,
	output logic signed [31:0]  r21,
	output logic signed [31:0]  r22,
	output logic signed [41:0]  delta_east,
	output logic signed [41:0]  delta_north,
	output logic signed [33:0]  delta_up
);
	localparam int unsigned W = iptlt_pkg::CordicW;
	localparam int unsigned N = iptlt_pkg::CordicSteps;
	localparam int unsigned Lat = N + 5;

	logic [43:0]        meridian_q, prime_q;
	logic signed [40:0] org_e_q, org_n_q;
	logic signed [31:0] org_u_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meridian_q <= '0; prime_q <= '0;
			org_e_q <= '0; org_n_q <= '0; org_u_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iptlt_pkg::RegMeridian: meridian_q <= cfg_data;
				iptlt_pkg::RegPrime:    prime_q <= cfg_data;
				iptlt_pkg::RegOrgEast:  org_e_q <= cfg_data[40:0];
				iptlt_pkg::RegOrgNorth: org_n_q <= cfg_data[40:0];
				iptlt_pkg::RegOrgUp:    org_u_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	logic take;
	assign take = start & ~busy;

	// valid shift line
	logic [Lat-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Lat-2:0], take};
	end

	// ---- angle fold, stage 0 (lanes: 0 roll, 1 pitch, 2 yaw)
	logic signed [W-1:0] ang [3];
	assign ang[0] = W'(roll);
	assign ang[1] = W'(pitch);
	assign ang[2] = W'(yaw);

	logic signed [W-1:0] x_s [N+1][3];
	logic signed [W-1:0] y_s [N+1][3];
	logic signed [W-1:0] z_s [N+1][3];
	logic                neg_s [N+1][3];

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			x_s[0][l] <= iptlt_pkg::CordicGain;
			y_s[0][l] <= '0;
			if (ang[l] > iptlt_pkg::HalfPiQ28) begin
				z_s[0][l] <= ang[l] - iptlt_pkg::PiQ28; neg_s[0][l] <= 1'b1;
			end else if (ang[l] < -iptlt_pkg::HalfPiQ28) begin
				z_s[0][l] <= ang[l] + iptlt_pkg::PiQ28; neg_s[0][l] <= 1'b1;
			end else begin
				z_s[0][l] <= ang[l]; neg_s[0][l] <= 1'b0;
			end
		end
	end

	// ---- CORDIC stages
	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			for (int l = 0; l < 3; l++) begin
				neg_s[i+1][l] <= neg_s[i][l];
				if (!z_s[i][l][W-1]) begin
					x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
					y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
					z_s[i+1][l] <= z_s[i][l] - iptlt_pkg::atan_q28(5'(i));
				end else begin
					x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
					y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
					z_s[i+1][l] <= z_s[i][l] + iptlt_pkg::atan_q28(5'(i));
				end
			end
		end
	end

	// ---- sign fix and clamp
	logic signed [31:0] c_s1 [3];
	logic signed [31:0] s_s1 [3];
	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			c_s1[l] <= iptlt_pkg::clamp_q30(neg_s[N][l] ? -x_s[N][l] : x_s[N][l]);
			s_s1[l] <= iptlt_pkg::clamp_q30(neg_s[N][l] ? -y_s[N][l] : y_s[N][l]);
		end
	end

	// ---- first products
	logic signed [33:0] cysp_s2, sysp_s2, cycp_s2, sycp_s2, sycr_s2, sysr_s2;
	logic signed [33:0] cycr_s2, cysr_s2, cpsr_s2, cpcr_s2;
	logic signed [31:0] sr_s2, cr_s2, sp_s2;
	always_ff @(posedge clk) begin
		cysp_s2 <= iptlt_pkg::mulq(c_s1[2], s_s1[1]);
		sysp_s2 <= iptlt_pkg::mulq(s_s1[2], s_s1[1]);
		cycp_s2 <= iptlt_pkg::mulq(c_s1[2], c_s1[1]);
		sycp_s2 <= iptlt_pkg::mulq(s_s1[2], c_s1[1]);
		sycr_s2 <= iptlt_pkg::mulq(s_s1[2], c_s1[0]);
		sysr_s2 <= iptlt_pkg::mulq(s_s1[2], s_s1[0]);
		cycr_s2 <= iptlt_pkg::mulq(c_s1[2], c_s1[0]);
		cysr_s2 <= iptlt_pkg::mulq(c_s1[2], s_s1[0]);
		cpsr_s2 <= iptlt_pkg::mulq(c_s1[1], s_s1[0]);
		cpcr_s2 <= iptlt_pkg::mulq(c_s1[1], c_s1[0]);
		sr_s2 <= s_s1[0]; cr_s2 <= c_s1[0]; sp_s2 <= s_s1[1];
	end

	// ---- triple products (inputs fit 32 bits: bounded by 2^30 in magnitude)
	logic signed [33:0] a01_s3, a02_s3, a11_s3, a12_s3;
	logic signed [33:0] b01_s3, b02_s3, b11_s3, b12_s3;
	logic signed [33:0] e00_s3, e10_s3, e20_s3, e21_s3, e22_s3;
	always_ff @(posedge clk) begin
		a01_s3 <= iptlt_pkg::mulq(cysp_s2[31:0], sr_s2);
		a02_s3 <= iptlt_pkg::mulq(cysp_s2[31:0], cr_s2);
		a11_s3 <= iptlt_pkg::mulq(sysp_s2[31:0], sr_s2);
		a12_s3 <= iptlt_pkg::mulq(sysp_s2[31:0], cr_s2);
		b01_s3 <= sycr_s2; b02_s3 <= sysr_s2; b11_s3 <= cycr_s2; b12_s3 <= cysr_s2;
		e00_s3 <= cycp_s2; e10_s3 <= sycp_s2; e20_s3 <= -34'(sp_s2);
		e21_s3 <= cpsr_s2; e22_s3 <= cpcr_s2;
	end

	// ---- sums and clamp
	logic signed [31:0] m_s4 [9];
	always_ff @(posedge clk) begin
		m_s4[0] <= iptlt_pkg::clamp_q30(e00_s3);
		m_s4[1] <= iptlt_pkg::clamp_q30(a01_s3 - b01_s3);
		m_s4[2] <= iptlt_pkg::clamp_q30(a02_s3 + b02_s3);
		m_s4[3] <= iptlt_pkg::clamp_q30(e10_s3);
		m_s4[4] <= iptlt_pkg::clamp_q30(a11_s3 + b11_s3);
		m_s4[5] <= iptlt_pkg::clamp_q30(a12_s3 - b12_s3);
		m_s4[6] <= iptlt_pkg::clamp_q30(e20_s3);
		m_s4[7] <= iptlt_pkg::clamp_q30(e21_s3);
		m_s4[8] <= iptlt_pkg::clamp_q30(e22_s3);
	end

	// ---- offset path: sign-magnitude, split products, round, subtract
	logic [31:0] mag_e_s1, mag_n_s1;
	logic        neg_e_s1, neg_n_s1;
	logic signed [33:0] up_s1;
	always_ff @(posedge clk) begin
		neg_e_s1 <= longitude[31];
		mag_e_s1 <= longitude[31] ? 32'(-33'(longitude)) : 32'(longitude);
		neg_n_s1 <= latitude[30];
		mag_n_s1 <= latitude[30] ? 32'(-32'(latitude)) : 32'(latitude);
		up_s1 <= 34'(height) - 34'(org_u_q);
	end

	logic [53:0] ha_e_s2, ha_n_s2;
	logic [53:0] lb_e_s2, lb_n_s2;
	logic        neg_e_s2, neg_n_s2;
	logic signed [33:0] up_s2;
	always_ff @(posedge clk) begin
		ha_e_s2 <= 54'(mag_e_s1) * 54'(prime_q[43:22]);
		lb_e_s2 <= 54'(mag_e_s1) * 54'(prime_q[21:0]);
		ha_n_s2 <= 54'(mag_n_s1) * 54'(meridian_q[43:22]);
		lb_n_s2 <= 54'(mag_n_s1) * 54'(meridian_q[21:0]);
		neg_e_s2 <= neg_e_s1; neg_n_s2 <= neg_n_s1; up_s2 <= up_s1;
	end

	// low partial product comes close to 2^53, so its carry into the quotient is wide
	logic [54:0] rem_e, rem_n;
	logic [37:0] q_e, q_n;
	assign rem_e = 55'({ha_e_s2[16:0], 22'd0}) + 55'(lb_e_s2) + (55'd1 << 38);
	assign rem_n = 55'({ha_n_s2[16:0], 22'd0}) + 55'(lb_n_s2) + (55'd1 << 38);
	assign q_e = 38'(ha_e_s2[53:17]) + 38'(rem_e[54:39]);
	assign q_n = 38'(ha_n_s2[53:17]) + 38'(rem_n[54:39]);

	logic signed [43:0] de_s3, dn_s3;
	logic signed [33:0] up_s3;
	always_ff @(posedge clk) begin
		de_s3 <= (neg_e_s2 ? -44'(q_e) : 44'(q_e)) - 44'(org_e_q);
		dn_s3 <= (neg_n_s2 ? -44'(q_n) : 44'(q_n)) - 44'(org_n_q);
		up_s3 <= up_s2;
	end

	function automatic logic signed [41:0] sat42(input logic signed [43:0] v);
		logic signed [41:0] r;
		if (v > 44'sd2199023255551) r = 42'sh1FFFFFFFFFF;
		else if (v < -44'sd2199023255552) r = 42'sh20000000000;
		else r = v[41:0];
		return r;
	endfunction

	// delay the offsets to line up with the matrix (matrix ready after Lat stages)
	localparam int unsigned Dly = Lat - 3;
	logic signed [41:0] de_d [Dly];
	logic signed [41:0] dn_d [Dly];
	logic signed [33:0] up_d [Dly];
	always_ff @(posedge clk) begin
		de_d[0] <= sat42(de_s3);
		dn_d[0] <= sat42(dn_s3);
		up_d[0] <= up_s3;
		for (int k = 1; k < Dly; k++) begin
			de_d[k] <= de_d[k-1]; dn_d[k] <= dn_d[k-1]; up_d[k] <= up_d[k-1];
		end
	end

	assign done = vld_q[Lat-1];
	assign r00 = m_s4[0]; assign r01 = m_s4[1]; assign r02 = m_s4[2];
	assign r10 = m_s4[3]; assign r11 = m_s4[4]; assign r12 = m_s4[5];
	assign r20 = m_s4[6]; assign r21 = m_s4[7]; assign r22 = m_s4[8];
	assign delta_east  = de_d[Dly-1];
	assign delta_north = dn_d[Dly-1];
	assign delta_up    = up_d[Dly-1];

endmodule

FILE: hdl/iptlt_checker.sv
// Port checker for the pose transform, bound to the top level.
module iptlt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] r00,
	input logic signed [31:0] r20,
	input logic signed [31:0] r22
);
	localparam int unsigned Lat = iptlt_pkg::CordicSteps + 5;
	logic [Lat-1:0] acc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_q <= '0;
		else acc_q <= {acc_q[Lat-2:0], start & ~busy};
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_done_match: assert property (@(posedge clk) disable iff (!arst_n)
		done == acc_q[Lat-1]) else $error("done does not match request");
	a_r00_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (r00 <= 32'sd1073741824 && r00 >= -32'sd1073741824))
		else $error("r00 out of range");
	a_r2_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (r20 <= 32'sd1073741824 && r22 <= 32'sd1073741824))
		else $error("row 2 out of range");
endmodule

bind imu_pose_to_local_transform iptlt_checker u_iptlt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.r00(r00), .r20(r20), .r22(r22)
);

FILE: tb/pose_transform_checker.sv
// Checker: predicts rotation and offsets per request and compares with each done pulse.
module pose_transform_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [30:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic signed [31:0] height,
	input  logic signed [30:0] roll,
	input  logic signed [30:0] pitch,
	input  logic signed [30:0] yaw,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [43:0]        cfg_data,
	input  logic               done,
	input  logic [31:0]        r00, r01, r02, r10, r11, r12, r20, r21, r22,
	input  logic [41:0]        delta_east,
	input  logic [41:0]        delta_north,
	input  logic [33:0]        delta_up,
	output int                 errors,
	output int                 pending
);
	typedef struct {
		logic [31:0] rot[9];
		logic [41:0] east;
		logic [41:0] north;
		logic [33:0] up;
	} pose_t;

	pose_t expected_poses[$];

	logic [43:0] meridian_scale, prime_scale;
	longint origin_east, origin_north, origin_up;

	localparam longint QOne = 64'sd1073741824;
	localparam longint SatLim = 64'sd2199023255552;

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic void trig(longint ang, output longint c, output longint s);
		longint x, y, z, nx, t;
		bit flip;
		flip = 0;
		if (ang > 64'sd421657428) begin
			ang -= 64'sd843314857;
			flip = 1;
		end else if (ang < -64'sd421657428) begin
			ang += 64'sd843314857;
			flip = 1;
		end
		x = 64'sd652032874;
		y = 0;
		z = ang;
		for (int i = 0; i < 28; i++) begin
			t = (i < 10) ? longint'(iptlt_pkg::atan_q28(i[4:0])) : (64'sd1 <<< (28 - i));
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= t;
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += t;
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = clip(x, -QOne, QOne);
		s = clip(y, -QOne, QOne);
	endfunction

	// scale*deg / 2^39, half away from zero, in 128-bit arithmetic
	function automatic longint scale_to_mm(logic [43:0] scale, longint deg);
		logic [127:0] p;
		longint q;
		p = 128'(deg < 0 ? -deg : deg) * 128'(scale);
		p = (p + (128'd1 << 38)) >> 39;
		q = longint'(p[63:0]);
		return deg < 0 ? -q : q;
	endfunction

	function automatic pose_t predict_pose(longint lat, longint lon, longint h,
			longint ro, longint pi_, longint ya);
		pose_t e;
		longint cr, sr, cp, sp, cy, sy, cysp, sysp;
		longint m[9];
		trig(ro, cr, sr);
		trig(pi_, cp, sp);
		trig(ya, cy, sy);
		cysp = qmul(cy, sp);
		sysp = qmul(sy, sp);
		m[0] = qmul(cy, cp);
		m[1] = qmul(cysp, sr) - qmul(sy, cr);
		m[2] = qmul(cysp, cr) + qmul(sy, sr);
		m[3] = qmul(sy, cp);
		m[4] = qmul(sysp, sr) + qmul(cy, cr);
		m[5] = qmul(sysp, cr) - qmul(cy, sr);
		m[6] = -sp;
		m[7] = qmul(cp, sr);
		m[8] = qmul(cp, cr);
		for (int j = 0; j < 9; j++) e.rot[j] = 32'(clip(m[j], -QOne, QOne));
		e.east = 42'(clip(scale_to_mm(prime_scale, lon) - origin_east, -SatLim, SatLim - 1));
		e.north = 42'(clip(scale_to_mm(meridian_scale, lat) - origin_north,
			-SatLim, SatLim - 1));
		e.up = 34'(h - origin_up);
		return e;
	endfunction

	assign pending = expected_poses.size();

	always @(posedge clk or negedge arst_n) begin
		pose_t e;
		logic [31:0] got[9];
		int nerr;
		if (!arst_n) begin
			errors <= 0;
			meridian_scale <= '0;
			prime_scale <= '0;
			origin_east <= 0;
			origin_north <= 0;
			origin_up <= 0;
			expected_poses.delete();
		end else begin
			nerr = 0;
			if (cfg_we) begin
				case (cfg_index)
					iptlt_pkg::RegMeridian: meridian_scale <= cfg_data;
					iptlt_pkg::RegPrime:    prime_scale <= cfg_data;
					iptlt_pkg::RegOrgEast:  origin_east <= longint'($signed(cfg_data[40:0]));
					iptlt_pkg::RegOrgNorth: origin_north <= longint'($signed(cfg_data[40:0]));
					iptlt_pkg::RegOrgUp:    origin_up <= longint'($signed(cfg_data[31:0]));
					default: ;
				endcase
			end
			if (done) begin
				got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
				if (expected_poses.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual r00=%h", $time, r00);
					nerr++;
				end else begin
					e = expected_poses.pop_front();
					for (int j = 0; j < 9; j++)
						if (got[j] !== e.rot[j]) begin
							$display("%0t: r%0d%0d expected %h actual %h",
								$time, j / 3, j % 3, e.rot[j], got[j]);
							nerr++;
						end
					if (delta_east !== e.east || delta_north !== e.north || delta_up !== e.up) begin
						$display("%0t: offset expected %h %h %h actual %h %h %h", $time,
							e.east, e.north, e.up, delta_east, delta_north, delta_up);
						nerr++;
					end
				end
			end
			errors <= errors + nerr;
			if (start && !busy)
				expected_poses = {expected_poses, predict_pose(latitude, longitude, height,
					roll, pitch, yaw)};
		end
	end
endmodule

FILE: tb/tb_imu_pose_to_local_transform.sv
// Testbench top: drives pose requests and register writes, reports the verdict.
module tb_imu_pose_to_local_transform;
	logic clk = 0, arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic signed [30:0] latitude = 0, roll = 0, pitch = 0, yaw = 0;
	logic signed [31:0] longitude = 0, height = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [43:0] cfg_data = '0;
	logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [41:0] delta_east, delta_north;
	logic signed [33:0] delta_up;
	int errors, pending;

	// wait past the pipeline before touching registers or ending
	localparam int Latency = 33;
	localparam int AngMax = 843314857;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	imu_pose_to_local_transform dut (.*);

	pose_transform_checker chk (.*);

	// write one register; the block must be idle
	task automatic write_reg(logic [2:0] idx, logic [43:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	// one request; start stays high across back-to-back requests
	task automatic send_pose(int lat, int lon, int h, int ro, int pi_, int ya, int gap);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		latitude <= lat[30:0];
		longitude <= lon;
		height <= h;
		roll <= ro[30:0];
		pitch <= pi_[30:0];
		yaw <= ya[30:0];
		do @(posedge clk); while (busy);
	endtask

	function automatic int rand_angle();
		// mostly in range, sometimes anywhere in 31 bits to exercise the fold
		if ($urandom_range(0, 7) == 0) return $signed(31'($urandom()));
		return $signed($urandom_range(0, 2 * AngMax)) - AngMax;
	endfunction

	function automatic int rand_gap();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
	endfunction

	task automatic random_config(int mode);
		logic [43:0] ms, ps;
		ms = (mode == 0) ? 44'hFFF_FFFF_FFFF : (mode == 1) ? 44'd0 :
			44'({$urandom(), $urandom()});
		ps = (mode == 0) ? 44'hFFF_FFFF_FFFF : (mode == 1) ? 44'd0 :
			44'({$urandom(), $urandom()});
		write_reg(iptlt_pkg::RegMeridian, ms);
		write_reg(iptlt_pkg::RegPrime, ps);
		write_reg(iptlt_pkg::RegOrgEast, (mode == 0) ? 44'h0FF_FFFF_FFFF :
			(mode == 1) ? 44'h100_0000_0000 : 44'({$urandom(), $urandom()}));
		write_reg(iptlt_pkg::RegOrgNorth, (mode == 0) ? 44'h100_0000_0000 :
			(mode == 1) ? 44'h0FF_FFFF_FFFF : 44'({$urandom(), $urandom()}));
		write_reg(iptlt_pkg::RegOrgUp, (mode == 0) ? 44'h0_8000_0000 :
			(mode == 1) ? 44'h0_7FFF_FFFF : 44'({$urandom(), $urandom()}));
		// index past the register list is ignored
		write_reg(3'd7, 44'({$urandom(), $urandom()}));
	endtask

	initial begin
		int lat_ext[3] = '{-754974720, 0, 754974720};
		int ang_ext[7] = '{-1073741824, -843314857, -421657429, 0, 421657429, 843314857,
			1073741823};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset registers, then extremes
		send_pose(0, 0, 0, 0, 0, 0, 0);
		start <= 0;
		drain();
		random_config(0);
		for (int k = 0; k < 7; k++)
			send_pose(lat_ext[k % 3], (k & 1) ? -1509949440 : 1509949440,
				(k & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
				ang_ext[k], ang_ext[(k + 2) % 7], ang_ext[(k + 4) % 7], 0);
		send_pose(-1, -1, -1, -1, -1, -1, 0);
		send_pose(1, 1, 1, 1, 1, 1, 0);
		// sender pauses until every expected result is back
		start <= 0;
		drain();
		random_config(1);
		for (int k = 0; k < 7; k++)
			send_pose(lat_ext[(k + 1) % 3], 1509949440 - k, k, ang_ext[6 - k], ang_ext[k],
				421657428, k);
		start <= 0;
		drain();

		// random phases with changing configuration
		for (int ph = 0; ph < 6; ph++) begin
			random_config(2);
			for (int n = 0; n < 190; n++)
				send_pose($signed($urandom_range(0, 1509949440)) - 754974720,
					($urandom_range(0, 5) == 0) ? $signed($urandom()) :
					$signed($urandom_range(0, 32'd3019898880)) - 1509949440,
					$signed($urandom()), rand_angle(), rand_angle(), rand_angle(),
					(ph == 2) ? 0 : rand_gap());
			start <= 0;
			drain();
		end

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
